FILE: sv/smed_pkg.sv
// Package: shared constants, transaction structs and sequencer states of the set median engine.
package smed_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int VALUE_BITS = 24;
   localparam int MED_BITS   = VALUE_BITS + 1;
   localparam int ADDR_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

   typedef struct packed {
      logic [VALUE_BITS-1:0] sample_value;
      logic                  carries_value;
      logic                  last_item;
   } req_type;

   typedef struct packed {
      logic [MED_BITS-1:0] median_doubled;
      logic                set_empty;
      logic                set_overflowed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_LATCH,
      ST_SWEEP,
      ST_RANK,
      ST_DONE
   } state_type;

endpackage

FILE: sv/set_median_engine_core.sv
// Top level: loads a set of values, then finds its median by rank counting.
// Loading: one value transaction per cycle while busy is low.
// After the last transaction, each stored value in turn becomes the candidate and is ranked
// by the single compare unit sweeping the store; an empty set goes straight to the done state.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Synchronous reset empties the set and returns the sequencer to idle.
module set_median_engine_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  smed_pkg::req_type req_item,
   output logic             rsp_valid,
   output smed_pkg::rsp_type rsp_item
);

   smed_pkg::state_type state_ff, state_in;

   logic [smed_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                            ovf_ff, ovf_in;
   logic [smed_pkg::CNT_W-1:0]      cand_idx_ff, cand_idx_in;
   logic [smed_pkg::CNT_W-1:0]      sweep_ff, sweep_in;
   logic                            cmp_vld_ff, cmp_vld_in;
   logic [smed_pkg::VALUE_BITS-1:0] cand_ff, cand_in;
   logic [smed_pkg::CNT_W-1:0]      lt_ff, lt_in;
   logic [smed_pkg::CNT_W-1:0]      eq_ff, eq_in;
   logic [smed_pkg::VALUE_BITS-1:0] lo_ff, lo_in;
   logic [smed_pkg::VALUE_BITS-1:0] hi_ff, hi_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   smed_pkg::rsp_type               rsp_ff, rsp_in;

   logic                            accept;
   logic                            full;
   logic                            wr_en;
   logic [smed_pkg::CNT_W-1:0]      cnt_next;
   logic [smed_pkg::ADDR_W-1:0]     rd_addr;
   logic [smed_pkg::VALUE_BITS-1:0] rd_data;
   logic [smed_pkg::CNT_W-1:0]      rank_hi;
   logic [smed_pkg::CNT_W-1:0]      k_lo;
   logic [smed_pkg::CNT_W-1:0]      k_hi;

   assign busy     = (state_ff != smed_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign full     = (cnt_ff >= smed_pkg::CNT_W'(smed_pkg::MAX_ITEMS));
   assign wr_en    = accept && req_item.carries_value && !full;
   assign cnt_next = cnt_ff + smed_pkg::CNT_W'(wr_en);
   assign rd_addr  = (state_ff == smed_pkg::ST_CAND) ? cand_idx_ff[smed_pkg::ADDR_W-1:0]
                                                    : sweep_ff[smed_pkg::ADDR_W-1:0];
   assign rank_hi  = lt_ff + eq_ff;
   assign k_lo     = (cnt_ff - smed_pkg::CNT_W'(1)) >> 1;
   assign k_hi     = cnt_ff >> 1;

   smed_store #(
      .DEPTH (smed_pkg::MAX_ITEMS),
      .WIDTH (smed_pkg::VALUE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[smed_pkg::ADDR_W-1:0]),
      .wr_data (req_item.sample_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smed_pkg::ST_IDLE: begin
            if (accept && req_item.last_item) begin
               state_in = (cnt_next == '0) ? smed_pkg::ST_DONE : smed_pkg::ST_CAND;
            end
         end
         smed_pkg::ST_CAND:  state_in = smed_pkg::ST_LATCH;
         smed_pkg::ST_LATCH: state_in = smed_pkg::ST_SWEEP;
         smed_pkg::ST_SWEEP: begin
            if (sweep_ff == cnt_ff) begin
               state_in = smed_pkg::ST_RANK;
            end
         end
         smed_pkg::ST_RANK: begin
            if (cand_idx_ff + smed_pkg::CNT_W'(1) == cnt_ff) begin
               state_in = smed_pkg::ST_DONE;
            end else begin
               state_in = smed_pkg::ST_CAND;
            end
         end
         smed_pkg::ST_DONE:  state_in = smed_pkg::ST_IDLE;
         default:            state_in = smed_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      cand_idx_in  = cand_idx_ff;
      sweep_in     = sweep_ff;
      cmp_vld_in   = 1'b0;
      cand_in      = cand_ff;
      lt_in        = lt_ff;
      eq_in        = eq_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         smed_pkg::ST_IDLE: begin
            cnt_in      = cnt_next;
            ovf_in      = ovf_ff || (accept && req_item.carries_value && full);
            cand_idx_in = '0;
         end
         smed_pkg::ST_CAND: begin
         end
         smed_pkg::ST_LATCH: begin
            cand_in  = rd_data;
            sweep_in = '0;
            lt_in    = '0;
            eq_in    = '0;
         end
         smed_pkg::ST_SWEEP: begin
            if (sweep_ff < cnt_ff) begin
               cmp_vld_in = 1'b1;
               sweep_in   = sweep_ff + smed_pkg::CNT_W'(1);
            end
            if (cmp_vld_ff) begin
               if (rd_data < cand_ff) begin
                  lt_in = lt_ff + smed_pkg::CNT_W'(1);
               end
               if (rd_data == cand_ff) begin
                  eq_in = eq_ff + smed_pkg::CNT_W'(1);
               end
            end
         end
         smed_pkg::ST_RANK: begin
            if (lt_ff <= k_lo && k_lo < rank_hi) begin
               lo_in = cand_ff;
            end
            if (lt_ff <= k_hi && k_hi < rank_hi) begin
               hi_in = cand_ff;
            end
            cand_idx_in = cand_idx_ff + smed_pkg::CNT_W'(1);
         end
         smed_pkg::ST_DONE: begin
            rsp_valid_in          = 1'b1;
            rsp_in.set_empty      = (cnt_ff == '0);
            rsp_in.set_overflowed = ovf_ff;
            if (cnt_ff == '0) begin
               rsp_in.median_doubled = '0;
            end else begin
               rsp_in.median_doubled = {1'b0, lo_ff} + {1'b0, hi_ff};
            end
            cnt_in = '0;
            ovf_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smed_pkg::ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_idx_ff <= cand_idx_in;
      sweep_ff    <= sweep_in;
      cand_ff     <= cand_in;
      lt_ff       <= lt_in;
      eq_ff       <= eq_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a preceding busy period");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.set_empty) |-> (rsp_item.median_doubled == '0))
      else $error("empty set with nonzero median");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= smed_pkg::CNT_W'(smed_pkg::MAX_ITEMS))
      else $error("value count beyond store depth");
`endif

endmodule

FILE: sv/smed_store.sv
// Value store: single write port, single registered read port.
module smed_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 24,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sim/smed_checker.sv
// Checker: watches the set median engine's channels, predicts each median and compares.
`timescale 1ns / 1ps
module smed_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  smed_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  smed_pkg::rsp_type rsp_item,
   output int                fail_count,
   output int                medians_owed,
   output int                medians_seen
);

   logic [smed_pkg::VALUE_BITS-1:0] set_values [smed_pkg::MAX_ITEMS];
   int                              set_size = 0;
   logic                            set_overflow = 1'b0;
   smed_pkg::rsp_type               expected_medians [$];
   int                              fails = 0;
   int                              seen = 0;

   function automatic smed_pkg::rsp_type median_of_set();
      logic [smed_pkg::VALUE_BITS-1:0] sorted [smed_pkg::MAX_ITEMS];
      logic [smed_pkg::VALUE_BITS-1:0] key;
      smed_pkg::rsp_type               med;
      int                              j;
      int                              mid;
      for (int i = 0; i < set_size; i++) sorted[i] = set_values[i];
      for (int i = 1; i < set_size; i++) begin
         key = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = key;
      end
      mid = set_size / 2;
      med.median_doubled = '0;
      med.set_empty      = (set_size == 0);
      med.set_overflowed = set_overflow;
      if (set_size % 2 == 1)
         med.median_doubled = {sorted[mid], 1'b0};
      else if (set_size > 0)
         med.median_doubled = {1'b0, sorted[mid-1]} + {1'b0, sorted[mid]};
      return med;
   endfunction

   function automatic void take_item(smed_pkg::req_type t);
      if (t.carries_value) begin
         if (set_size < smed_pkg::MAX_ITEMS) begin
            set_values[set_size] = t.sample_value;
            set_size++;
         end else begin
            set_overflow = 1'b1;
         end
      end
      if (t.last_item) begin
         expected_medians = {expected_medians, median_of_set()};
         set_size = 0;
         set_overflow = 1'b0;
      end
   endfunction

   function automatic void check_median(smed_pkg::rsp_type got);
      smed_pkg::rsp_type want;
      seen++;
      if (expected_medians.size() == 0) begin
         $error("median result with none expected: %h", got);
         fails++;
      end else begin
         want = expected_medians.pop_front();
         if (got.median_doubled !== want.median_doubled) begin
            $error("median_doubled: expected %h, got %h", want.median_doubled,
                   got.median_doubled);
            fails++;
         end
         if (got.set_empty !== want.set_empty) begin
            $error("set_empty: expected %b, got %b", want.set_empty, got.set_empty);
            fails++;
         end
         if (got.set_overflowed !== want.set_overflowed) begin
            $error("set_overflowed: expected %b, got %b", want.set_overflowed,
                   got.set_overflowed);
            fails++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         set_size = 0;
         set_overflow = 1'b0;
         expected_medians.delete();
      end else begin
         if (rsp_valid) check_median(rsp_item);
         if (start && !busy) take_item(req_item);
      end
      fail_count   <= fails;
      medians_owed <= expected_medians.size();
      medians_seen <= seen;
   end

endmodule

FILE: sim/tb_top.sv
// Testbench top: drives value and close transactions into the set median engine and reports.
`timescale 1ns / 1ps
module tb_top;

   localparam int ITEM_TARGET   = 2000;
   localparam int CALM_TAIL     = 200;
   localparam int LARGE_SET_CAP = 12;
   localparam int DRAIN_CYCLES  = smed_pkg::MAX_ITEMS * (smed_pkg::MAX_ITEMS + 4) + 2;
   localparam logic [smed_pkg::VALUE_BITS-1:0] VALUE_MAX = '1;

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   smed_pkg::req_type req_item = '0;
   logic              busy;
   logic              rsp_valid;
   smed_pkg::rsp_type rsp_item;

   int fail_count;
   int medians_owed;
   int medians_seen;
   int items_sent = 0;
   int sets_sent  = 0;
   int large_sets = 0;

   always #2 clock = ~clock;

   set_median_engine_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   smed_checker median_check (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item),
      .fail_count   (fail_count),
      .medians_owed (medians_owed),
      .medians_seen (medians_seen)
   );

   task automatic push_item(input logic [smed_pkg::VALUE_BITS-1:0] v, input logic c,
                            input logic l);
      smed_pkg::req_type t;
      t.sample_value  = v;
      t.carries_value = c;
      t.last_item     = l;
      if (items_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (c || l) items_sent++;
   endtask

   function automatic logic [smed_pkg::VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return VALUE_MAX;
         2:       return smed_pkg::VALUE_BITS'($urandom_range(0, 15));
         3:       return smed_pkg::VALUE_BITS'(1) << $urandom_range(0, smed_pkg::VALUE_BITS - 1);
         default: return smed_pkg::VALUE_BITS'($urandom);
      endcase
   endfunction

   // close either on the final value or with a separate close-only transaction
   task automatic send_set(input int n, input bit close_on_value);
      int plain;
      plain = (close_on_value && n > 0) ? n - 1 : n;
      for (int i = 0; i < plain; i++) begin
         if ($urandom_range(0, 19) == 0)
            push_item(smed_pkg::VALUE_BITS'($urandom), 1'b0, 1'b0);
         push_item(pick_value(), 1'b1, 1'b0);
      end
      if (close_on_value && n > 0)
         push_item(pick_value(), 1'b1, 1'b1);
      else
         push_item(smed_pkg::VALUE_BITS'($urandom), 1'b0, 1'b1);
      sets_sent++;
   endtask

   initial begin
      int n;
      int pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      push_item('0, 1'b0, 1'b1);
      push_item(VALUE_MAX, 1'b0, 1'b0);
      push_item(VALUE_MAX, 1'b0, 1'b1);
      push_item(VALUE_MAX, 1'b1, 1'b1);
      push_item('0, 1'b1, 1'b1);
      push_item(VALUE_MAX, 1'b1, 1'b0);
      push_item(VALUE_MAX, 1'b1, 1'b0);
      push_item('0, 1'b0, 1'b1);
      push_item(24'd1, 1'b1, 1'b0);
      push_item(24'd2, 1'b1, 1'b1);
      push_item(24'd9, 1'b1, 1'b0);
      push_item('0, 1'b1, 1'b0);
      push_item(VALUE_MAX, 1'b1, 1'b1);
      push_item(24'd5, 1'b1, 1'b0);
      push_item(24'd7, 1'b1, 1'b0);
      push_item(24'd5, 1'b1, 1'b0);
      push_item(24'd5, 1'b1, 1'b0);
      push_item(VALUE_MAX, 1'b0, 1'b1);
      sets_sent += 8;
      send_set(smed_pkg::MAX_ITEMS + 6, 1'b1);
      push_item(24'd4, 1'b1, 1'b1);
      sets_sent++;
      large_sets++;

      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 3 && large_sets < LARGE_SET_CAP) begin
            case ($urandom_range(0, 2))
               0:       n = smed_pkg::MAX_ITEMS;
               1:       n = smed_pkg::MAX_ITEMS + 1;
               default: n = $urandom_range(smed_pkg::MAX_ITEMS - 4, smed_pkg::MAX_ITEMS + 16);
            endcase
            large_sets++;
         end else if (pick < 12) begin
            n = 0;
         end else if (pick < 40) begin
            n = $urandom_range(1, 3);
         end else begin
            n = $urandom_range(4, 16);
         end
         send_set(n, $urandom_range(0, 1));
      end

      start <= 1'b0;
      @(posedge clock);
      while (medians_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d value/close transactions in %0d sets, %0d near or past capacity",
               items_sent, sets_sent, large_sets);
      $display("checked %0d median results", medians_seen);
      if (fail_count == 0 && medians_owed == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
